### design/cvl_pkg.sv
// Package: shared widths, operation and status codes, controller/datapath interface structs.
`timescale 1ns / 1ps
`default_nettype none
package cvl_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 7;

   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic load;
      logic append;
      logic flag_full;
      logic flag_range;
      logic rd_index;
      logic rd_first;
      logic rd_next;
      logic shift_wr;
      logic capture_read;
      logic remove_commit;
      logic post;
   } cvl_cmd_type;

   typedef struct packed {
      logic full;
      logic in_range;
      logic empty;
      logic match;
      logic last;
      logic out_free;
   } cvl_stat_type;

endpackage
`default_nettype wire

### design/cvl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cvl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### design/cvl_datapath.sv
// Datapath: entry memory, length and sum registers, scan pointer, result registers.
`timescale 1ns / 1ps
`default_nettype none
module cvl_datapath #(
   parameter int CAPACITY = cvl_pkg::CAPACITY_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire cvl_pkg::cvl_cmd_type                 cmd,
   output cvl_pkg::cvl_stat_type                     stat,
   input  wire logic signed [cvl_pkg::VALUE_W-1:0]   req_value,
   input  wire logic        [cvl_pkg::INDEX_W-1:0]   req_index,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed      [cvl_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic                                      rsp_found,
   output logic             [cvl_pkg::STATUS_W-1:0]  rsp_status,
   output logic             [cvl_pkg::LENGTH_W-1:0]  rsp_length,
   output logic signed      [cvl_pkg::VALUE_W-1:0]   rsp_total
);
   import cvl_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

   logic [CW-1:0]       count_ff, count_in;
   logic [VALUE_W-1:0]  sum_ff, sum_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [VALUE_W-1:0]  res_read_value_ff, res_read_value_in;
   logic                res_found_ff, res_found_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_read_value_ff;
   logic                rsp_found_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LENGTH_W-1:0] rsp_length_ff;
   logic [VALUE_W-1:0]  rsp_total_ff;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [VALUE_W-1:0]  wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [VALUE_W-1:0]  rd_data;
   logic [AW-1:0]       ptr_next;

   cvl_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ptr_next = ptr_ff + AW'(1);

   always_comb begin
      stat.full     = (count_ff == CW'(CAPACITY));
      stat.in_range = (XW'(req_index) < XW'(count_ff));
      stat.empty    = (count_ff == '0);
      stat.match    = (rd_data == val_ff);
      stat.last     = !((CW'(ptr_ff) + CW'(1)) < count_ff);
      stat.out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      wr_en   = cmd.append || cmd.shift_wr;
      wr_addr = cmd.append ? AW'(count_ff) : (ptr_ff - AW'(1));
      wr_data = cmd.append ? VALUE_W'(req_value) : rd_data;

      rd_en = cmd.rd_index || cmd.rd_first || cmd.rd_next;
      priority if (cmd.rd_index) begin
         rd_addr = AW'(req_index);
      end else if (cmd.rd_first) begin
         rd_addr = '0;
      end else begin
         rd_addr = ptr_next;
      end

      ptr_in = ptr_ff;
      if (cmd.rd_first) begin
         ptr_in = '0;
      end else if (cmd.rd_next) begin
         ptr_in = ptr_next;
      end

      val_in = cmd.load ? VALUE_W'(req_value) : val_ff;

      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.append) begin
         count_in = count_ff + CW'(1);
         sum_in   = sum_ff + VALUE_W'(req_value);
      end else if (cmd.remove_commit) begin
         count_in = count_ff - CW'(1);
         sum_in   = sum_ff - val_ff;
      end

      res_read_value_in = res_read_value_ff;
      if (cmd.load) begin
         res_read_value_in = '0;
      end else if (cmd.capture_read) begin
         res_read_value_in = rd_data;
      end

      res_found_in = res_found_ff;
      if (cmd.load) begin
         res_found_in = 1'b0;
      end else if (cmd.remove_commit) begin
         res_found_in = 1'b1;
      end

      priority if (cmd.flag_full) begin
         res_status_in = ST_FULL;
      end else if (cmd.flag_range) begin
         res_status_in = ST_RANGE;
      end else if (cmd.load) begin
         res_status_in = ST_OK;
      end else begin
         res_status_in = res_status_ff;
      end

      if (cmd.post) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff            <= val_in;
      ptr_ff            <= ptr_in;
      res_read_value_ff <= res_read_value_in;
      res_found_ff      <= res_found_in;
      res_status_ff     <= res_status_in;
      if (cmd.post) begin
         rsp_read_value_ff <= res_read_value_ff;
         rsp_found_ff      <= res_found_ff;
         rsp_status_ff     <= res_status_ff;
         rsp_length_ff     <= LENGTH_W'(count_ff);
         rsp_total_ff      <= sum_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_length     = rsp_length_ff;
   assign rsp_total      = rsp_total_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list length above capacity");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.append && cmd.shift_wr))
      else $error("append and shift write in the same cycle");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.remove_commit |=> count_ff == $past(count_ff) - CW'(1))
      else $error("remove did not shrink the list by one");

   a_post_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.post |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result posted over a held word");

endmodule
`default_nettype wire

### design/cvl_ctrl.sv
// Controller: sequences append, read, and remove scan/shift over the entry memory.
`timescale 1ns / 1ps
`default_nettype none
module cvl_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [cvl_pkg::KIND_W-1:0]    req_kind,
   input  wire cvl_pkg::cvl_stat_type         stat,
   output cvl_pkg::cvl_cmd_type               cmd
);
   import cvl_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_RDWAIT = 5'b00010,
      S_SCAN   = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_FINISH;
               unique case (req_kind)
                  KIND_APPEND: begin
                     if (stat.full) begin
                        cmd.flag_full = 1'b1;
                     end else begin
                        cmd.append = 1'b1;
                     end
                  end
                  KIND_REMOVE: begin
                     if (!stat.empty) begin
                        cmd.rd_first = 1'b1;
                        state_in     = S_SCAN;
                     end
                  end
                  KIND_READ: begin
                     if (stat.in_range) begin
                        cmd.rd_index = 1'b1;
                        state_in     = S_RDWAIT;
                     end else begin
                        cmd.flag_range = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            cmd.capture_read = 1'b1;
            state_in         = S_FINISH;
         end
         S_SCAN: begin
            if (stat.match) begin
               if (stat.last) begin
                  cmd.remove_commit = 1'b1;
                  state_in          = S_FINISH;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = S_SHIFT;
               end
            end else if (stat.last) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         S_SHIFT: begin
            cmd.shift_wr = 1'b1;
            if (stat.last) begin
               cmd.remove_commit = 1'b1;
               state_in          = S_FINISH;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.post = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted word left controller idle");

   a_shift_from_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> ($past(state_ff) == S_SCAN || $past(state_ff) == S_SHIFT))
      else $error("shift entered without a scan hit");

   a_finish_posts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && stat.out_free) |=> (state_ff == S_IDLE))
      else $error("finish did not return to idle");

endmodule
`default_nettype wire

### design/compacting_value_list_top.sv
// Top level: compacting value list with append, remove-by-value and indexed read.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_stall  | req_kind, req_value, req_index
//  rsp     | out | rsp_valid/rsp_stall  | rsp_read_value, rsp_found, rsp_status,
//          |     |                      | rsp_length, rsp_total
//
// Append, kind 3, full append and out-of-range read go from idle straight to the finish state.
// Read in range passes through a read-wait state (one memory read with registered data).
// Remove: scans the entries, then shifts the later entries down after a match; the single
//   memory read port visits one entry per cycle for both the search and the shift.
// Reset clears the controller state, length, sum and result valid flag only; entry memory needs no clearing pass.
// A result word holds in its output register while rsp_stall is high; the next request
//   is taken once that word has been handed to the output register.
`timescale 1ns / 1ps
`default_nettype none
module compacting_value_list_top #(
   parameter int CAPACITY = cvl_pkg::CAPACITY_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic        [cvl_pkg::KIND_W-1:0]    req_kind,
   input  wire logic signed [cvl_pkg::VALUE_W-1:0]   req_value,
   input  wire logic        [cvl_pkg::INDEX_W-1:0]   req_index,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed      [cvl_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic                                      rsp_found,
   output logic             [cvl_pkg::STATUS_W-1:0]  rsp_status,
   output logic             [cvl_pkg::LENGTH_W-1:0]  rsp_length,
   output logic signed      [cvl_pkg::VALUE_W-1:0]   rsp_total
);
   import cvl_pkg::*;

   cvl_cmd_type  cmd;
   cvl_stat_type stat;

   cvl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .stat      (stat),
      .cmd       (cmd)
   );

   cvl_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length),
      .rsp_total      (rsp_total)
   );

endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for compacting_value_list_top: directed, fill/empty and random append/remove/read traffic vs. a list model.
`timescale 1ns / 1ps
module testbench;
   import cvl_pkg::*;

   localparam int LIST_CAP = CAPACITY_DEF;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES = 200;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  read_value;
      logic                       found;
      logic        [STATUS_W-1:0] status;
      logic        [LENGTH_W-1:0] length;
      logic signed [VALUE_W-1:0]  total;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KIND_W-1:0] req_kind = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [INDEX_W-1:0] req_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic rsp_found;
   logic [STATUS_W-1:0] rsp_status;
   logic [LENGTH_W-1:0] rsp_length;
   logic signed [VALUE_W-1:0] rsp_total;

   // list model state
   logic [VALUE_W-1:0] list_vals [LIST_CAP];
   int held = 0;
   logic [VALUE_W-1:0] list_sum = '0;

   list_result_type pending_results[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;

   compacting_value_list_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length),
      .rsp_total      (rsp_total)
   );

   always #1 clock = ~clock;

   function automatic list_result_type apply_list_op(input logic [KIND_W-1:0] kind,
                                                     input logic [VALUE_W-1:0] value,
                                                     input logic [INDEX_W-1:0] index);
      list_result_type r;
      int hit;
      r = '0;
      hit = -1;
      case (kind)
         KIND_APPEND: begin
            if (held >= LIST_CAP) begin
               r.status = ST_FULL;
            end else begin
               list_vals[held] = value;
               held++;
               list_sum += value;
            end
         end
         KIND_REMOVE: begin
            for (int i = 0; i < held; i++)
               if (hit < 0 && list_vals[i] == value) hit = i;
            if (hit >= 0) begin
               for (int j = hit; j + 1 < held; j++) list_vals[j] = list_vals[j + 1];
               held--;
               list_sum -= value;
               r.found = 1'b1;
            end
         end
         KIND_READ: begin
            if (int'(index) < held) r.read_value = list_vals[index];
            else r.status = ST_RANGE;
         end
         default: ;
      endcase
      r.length = LENGTH_W'(held);
      r.total = list_sum;
      return r;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return VALUE_W'($urandom_range(0, 7)) - 32'd4;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                            input logic [INDEX_W-1:0] index);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value <= value;
      req_index <= index;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(apply_list_op(kind, value, index));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic remove_present();
      send_word(KIND_REMOVE, list_vals[$urandom_range(0, held - 1)], INDEX_W'($urandom));
   endtask

   task automatic test_directed();
      send_word(KIND_READ, 32'd0, 6'd0);
      send_word(KIND_REMOVE, 32'd0, 6'd0);
      send_word(KIND_UNUSED, 32'hffff_ffff, 6'd63);
      send_word(KIND_APPEND, 32'h7fff_ffff, 6'd63);
      send_word(KIND_APPEND, 32'h0000_0001, 6'd0);
      send_word(KIND_APPEND, 32'h8000_0000, 6'd21);
      send_word(KIND_APPEND, 32'h0000_0000, 6'd42);
      send_word(KIND_APPEND, 32'hffff_ffff, 6'd0);
      send_word(KIND_APPEND, 32'h0000_0001, 6'd0);
      send_word(KIND_READ, 32'hffff_ffff, 6'd0);
      send_word(KIND_READ, 32'd0, 6'd5);
      send_word(KIND_READ, 32'd0, 6'd6);
      send_word(KIND_READ, 32'd0, 6'd63);
      // duplicate value: only the first copy goes
      send_word(KIND_REMOVE, 32'h0000_0001, 6'd0);
      send_word(KIND_READ, 32'd0, 6'd1);
      send_word(KIND_REMOVE, 32'd12345, 6'd0);
      send_word(KIND_REMOVE, 32'hffff_ffff, 6'd0);
      send_word(KIND_REMOVE, 32'h7fff_ffff, 6'd0);
      send_word(KIND_REMOVE, 32'h0000_0001, 6'd0);
      send_word(KIND_UNUSED, 32'h5555_aaaa, 6'd42);
      send_word(KIND_REMOVE, 32'h0000_0000, 6'd0);
      send_word(KIND_REMOVE, 32'h8000_0000, 6'd0);
      send_word(KIND_READ, 32'd0, 6'd0);
   endtask

   task automatic test_fill_and_empty();
      while (held < LIST_CAP) send_word(KIND_APPEND, pick_value(), INDEX_W'($urandom));
      repeat (3) send_word(KIND_APPEND, pick_value(), INDEX_W'($urandom));
      send_word(KIND_UNUSED, $urandom, INDEX_W'($urandom));
      send_word(KIND_READ, $urandom, 6'd63);
      send_word(KIND_READ, $urandom, 6'd0);
      send_word(KIND_REMOVE, list_vals[LIST_CAP - 1], 6'd0);
      send_word(KIND_READ, $urandom, 6'd63);
      send_word(KIND_APPEND, pick_value(), 6'd0);
      send_word(KIND_REMOVE, list_vals[0], 6'd0);
      send_word(KIND_APPEND, pick_value(), 6'd0);
      while (held > 0) begin
         if ($urandom_range(0, 7) == 0)
            send_word(KIND_READ, $urandom, INDEX_W'($urandom_range(0, held - 1)));
         remove_present();
      end
      send_word(KIND_REMOVE, pick_value(), 6'd0);
      send_word(KIND_READ, $urandom, INDEX_W'($urandom));
   endtask

   task automatic test_random_mix(input int n_words);
      int target;
      int pick;
      int k;
      target = $urandom_range(0, LIST_CAP);
      for (k = 0; k < n_words; k++) begin
         if (k % 300 == 150) quiet = 1'b1;
         if (k % 300 == 220) quiet = 1'b0;
         if (k == n_words / 2) drain_results();
         if ($urandom_range(0, 49) == 0) target = $urandom_range(0, LIST_CAP);
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_word(KIND_UNUSED, $urandom, INDEX_W'($urandom));
         end else if (pick < 38) begin
            if (held > 0 && $urandom_range(0, 4) != 0)
               send_word(KIND_READ, $urandom, INDEX_W'($urandom_range(0, held - 1)));
            else
               send_word(KIND_READ, $urandom, INDEX_W'($urandom));
         end else if (held < target || (held == target && $urandom_range(0, 1) == 0)) begin
            send_word(KIND_APPEND, pick_value(), INDEX_W'($urandom));
         end else if (held > 0 && $urandom_range(0, 5) != 0) begin
            remove_present();
         end else begin
            send_word(KIND_REMOVE, pick_value(), INDEX_W'($urandom));
         end
      end
      quiet = 1'b0;
   endtask

   // result side back-pressure
   initial begin
      int n;
      forever begin
         n = quiet ? 0 : $urandom_range(0, 3);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   always @(posedge clock) begin
      list_result_type exp_r;
      list_result_type got_r;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got_r = {rsp_read_value, rsp_found, rsp_status, rsp_length, rsp_total};
         if (pending_results.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result word: rd=%0d found=%0d st=%0d len=%0d total=%0d",
                        got_r.read_value, got_r.found, got_r.status, got_r.length, got_r.total);
            mismatches++;
         end else begin
            exp_r = pending_results.pop_front();
            if (got_r.read_value !== exp_r.read_value || got_r.found !== exp_r.found ||
                got_r.status !== exp_r.status || got_r.length !== exp_r.length ||
                got_r.total !== exp_r.total) begin
               if (mismatches < 10) begin
                  $display("mismatch: exp rd=%0d found=%0d st=%0d len=%0d total=%0d",
                           exp_r.read_value, exp_r.found, exp_r.status, exp_r.length,
                           exp_r.total);
                  $display("          got rd=%0d found=%0d st=%0d len=%0d total=%0d",
                           got_r.read_value, got_r.found, got_r.status, got_r.length,
                           got_r.total);
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("compacting_value_list_top test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain_results();
      test_fill_and_empty();
      drain_results();
      test_random_mix(1400);
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("compacting_value_list_top test passed");
      else
         $display("compacting_value_list_top test failed");
      $finish;
   end

endmodule
